/* design/lslc_pkg.sv */
// shared types, constants and helpers for the led strobe light controller
`default_nettype none
package lslc_pkg;

  // number of light channels held in the backup store
  localparam int unsigned Channels = 3;

  // field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned ChW     = 2;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned DutyW   = 9;
  localparam int unsigned LenW    = 10;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned GuardW  = 8;

  // stream word widths, padded to whole bytes
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 8;
  localparam int unsigned OutDataW = 40;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // reset values
  localparam logic [PeriodW-1:0] PeriodReset = 16'd2048;
  localparam logic [GuardW-1:0]  GuardReset  = 8'd3;
  // pulse end used when the infrared level is zero
  localparam logic [LenW-1:0]    LenDefault  = 10'd512;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STROBE_PERIOD = 1'b0,
    REG_EDGE_GUARD    = 1'b1
  } cfg_reg_e;

  // event codes
  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_TRIG_RISE  = 3'd1,
    OP_TRIG_FALL  = 3'd2,
    OP_SOFT_PULSE = 3'd3,
    OP_SET_LEVEL  = 3'd4,
    OP_ACTIVATE   = 3'd5,
    OP_DEACTIVATE = 3'd6,
    OP_UNUSED     = 3'd7
  } op_e;

  // channel codes
  typedef enum logic [ChW-1:0] {
    CH_UV      = 2'd0,
    CH_VIS     = 2'd1,
    CH_IR      = 2'd2,
    CH_INVALID = 2'd3
  } chan_e;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [LenW-1:0]  strobe_length;
    logic             vis_on;
    logic [DutyW-1:0] vis_duty;
    logic             uv_on;
    logic [DutyW-1:0] uv_duty;
    logic             output_active;
    logic             strobe_armed;
    logic             strobe_out;
  } result_t;

  // compare value for a light channel: 2*level+1, or 0 when off
  function automatic logic [DutyW-1:0] duty_of(input logic [LevelW-1:0] lvl);
    duty_of = (lvl != '0) ? {lvl, 1'b1} : '0;
  endfunction

  // pulse end count for the strobe: 2*level, or the default when zero
  function automatic logic [LenW-1:0] len_of(input logic [LevelW-1:0] lvl);
    len_of = (lvl != '0) ? {1'b0, lvl, 1'b0} : LenDefault;
  endfunction

endpackage
`default_nettype wire

/* design/led_strobe_light_controller.sv */
// top level: event decoder, light state and strobe timer with registered result
//
// Usage:
//   s_axis carries one event word per handshake: tuser holds the opcode,
//   tdata the channel and level. m_axis returns exactly one result word per
//   event: strobe drive, armed flag, active flag, both light compare values
//   and enables, and the strobe pulse end count, all as they stand after the
//   event. cfg_we_i/cfg_idx_i/cfg_data_i write strobe_period (index 0) and
//   edge_guard (index 1); write them only while no event is in flight.
//   The registered result word appears on m_axis in the cycle after the
//   event is accepted. One event per cycle while results are taken; the
//   state update is a single level of compare and select logic feeding the
//   state and result registers. The input is ready whenever the result register is
//   empty or being taken in the same cycle, so a stalled receiver holds the
//   result word steady and back-pressures the input after one buffered word.
//   Reset: outputs inactive and zero, strobe armed, pulse end 512, timer
//   stopped at zero, backup levels zero, period 2048 and edge guard 3.
`default_nettype none
module led_strobe_light_controller (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // event input
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] channel, [9:2] level, rest zero
  input  wire  [lslc_pkg::InDataW-1:0]         s_axis_tdata,
  // [2:0] opcode, rest zero
  input  wire  [lslc_pkg::InUserW-1:0]         s_axis_tuser,
  // result output
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [0] strobe_out, [1] strobe_armed, [2] output_active, [11:3] uv_duty,
  // [12] uv_on, [21:13] vis_duty, [22] vis_on, [32:23] strobe_length, rest zero
  output logic [lslc_pkg::OutDataW-1:0]        m_axis_tdata,
  // configuration writes
  input  wire                                  cfg_we_i,
  input  wire  [lslc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire  [lslc_pkg::CfgDataW-1:0]        cfg_data_i
);

  // configuration registers
  logic [lslc_pkg::PeriodW-1:0] period_q;
  logic [lslc_pkg::GuardW-1:0]  guard_q;

  // block state
  logic                         active_q,  active_d;
  logic                         armed_q,   armed_d;
  logic [lslc_pkg::LevelW-1:0]  saved_q [lslc_pkg::Channels];
  logic [lslc_pkg::LevelW-1:0]  saved_d [lslc_pkg::Channels];
  logic                         run_q,     run_d;
  logic [lslc_pkg::TimerW-1:0]  count_q,   count_d;
  logic                         strobe_q,  strobe_d;
  logic [lslc_pkg::DutyW-1:0]   uv_cmp_q,  uv_cmp_d;
  logic                         uv_en_q,   uv_en_d;
  logic [lslc_pkg::DutyW-1:0]   vis_cmp_q, vis_cmp_d;
  logic                         vis_en_q,  vis_en_d;
  logic [lslc_pkg::LenW-1:0]    pend_q,    pend_d;

  // result register
  logic                         out_vld_q;
  lslc_pkg::result_t            res_q, res_d;

  // input word fields
  lslc_pkg::op_e                op;
  logic [lslc_pkg::ChW-1:0]     chan;
  logic [lslc_pkg::LevelW-1:0]  lvl;
  logic                         accept;
  logic [lslc_pkg::TimerW-1:0]  count_inc;
  logic                         above_guard;

  assign op     = lslc_pkg::op_e'(s_axis_tuser[lslc_pkg::OpW-1:0]);
  assign chan   = s_axis_tdata[lslc_pkg::ChW-1:0];
  assign lvl    = s_axis_tdata[lslc_pkg::ChW +: lslc_pkg::LevelW];

  // handshake
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign count_inc   = count_q + 1'b1;
  assign above_guard = count_q > {{(lslc_pkg::TimerW-lslc_pkg::GuardW){1'b0}}, guard_q};

  // next state for one event
  always_comb begin
    active_d  = active_q;
    armed_d   = armed_q;
    saved_d   = saved_q;
    run_d     = run_q;
    count_d   = count_q;
    strobe_d  = strobe_q;
    uv_cmp_d  = uv_cmp_q;
    uv_en_d   = uv_en_q;
    vis_cmp_d = vis_cmp_q;
    vis_en_d  = vis_en_q;
    pend_d    = pend_q;
    case (op)
      lslc_pkg::OP_TICK: begin
        if (run_q) begin
          count_d = count_inc;
          if (count_inc == {{(lslc_pkg::TimerW-lslc_pkg::LenW){1'b0}}, pend_q}) begin
            strobe_d = 1'b0;
          end
          if (count_inc == period_q) begin
            run_d   = 1'b0;
            count_d = '0;
            armed_d = 1'b1;
          end
        end
      end
      lslc_pkg::OP_TRIG_RISE: begin
        if ((!armed_q && above_guard) || !active_q) begin
          strobe_d = 1'b0;
        end else begin
          armed_d  = 1'b0;
          strobe_d = 1'b1;
          run_d    = 1'b1;
        end
      end
      lslc_pkg::OP_TRIG_FALL: begin
        if (above_guard) begin
          strobe_d = 1'b0;
        end
      end
      lslc_pkg::OP_SOFT_PULSE: begin
        if (!armed_q || !active_q) begin
          strobe_d = 1'b0;
        end else begin
          armed_d  = 1'b0;
          strobe_d = 1'b1;
          run_d    = 1'b1;
        end
      end
      lslc_pkg::OP_SET_LEVEL: begin
        if (chan != lslc_pkg::CH_INVALID) begin
          if (!active_q) begin
            saved_d[chan] = lvl;
          end else begin
            case (chan)
              lslc_pkg::CH_UV: begin
                uv_cmp_d = lslc_pkg::duty_of(lvl);
                uv_en_d  = lvl != '0;
              end
              lslc_pkg::CH_VIS: begin
                vis_cmp_d = lslc_pkg::duty_of(lvl);
                vis_en_d  = lvl != '0;
              end
              default: begin
                pend_d = lslc_pkg::len_of(lvl);
              end
            endcase
          end
        end
      end
      lslc_pkg::OP_ACTIVATE: begin
        if (!active_q) begin
          active_d  = 1'b1;
          uv_cmp_d  = lslc_pkg::duty_of(saved_q[lslc_pkg::CH_UV]);
          uv_en_d   = saved_q[lslc_pkg::CH_UV] != '0;
          vis_cmp_d = lslc_pkg::duty_of(saved_q[lslc_pkg::CH_VIS]);
          vis_en_d  = saved_q[lslc_pkg::CH_VIS] != '0;
          pend_d    = lslc_pkg::len_of(saved_q[lslc_pkg::CH_IR]);
        end
      end
      lslc_pkg::OP_DEACTIVATE: begin
        if (active_q) begin
          saved_d[lslc_pkg::CH_UV]  = uv_cmp_q[lslc_pkg::DutyW-1:1];
          saved_d[lslc_pkg::CH_VIS] = vis_cmp_q[lslc_pkg::DutyW-1:1];
          saved_d[lslc_pkg::CH_IR]  = (pend_q == lslc_pkg::LenDefault) ? '0
                                    : pend_q[lslc_pkg::LevelW:1];
          active_d  = 1'b0;
          uv_cmp_d  = '0;
          uv_en_d   = 1'b0;
          vis_cmp_d = '0;
          vis_en_d  = 1'b0;
          pend_d    = lslc_pkg::LenDefault;
          strobe_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result word built from the updated state
  always_comb begin
    res_d.strobe_out    = strobe_d;
    res_d.strobe_armed  = armed_d;
    res_d.output_active = active_d;
    res_d.uv_duty       = uv_cmp_d;
    res_d.uv_on         = uv_en_d;
    res_d.vis_duty      = vis_cmp_d;
    res_d.vis_on        = vis_en_d;
    res_d.strobe_length = pend_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= lslc_pkg::PeriodReset;
      guard_q  <= lslc_pkg::GuardReset;
    end else if (cfg_we_i) begin
      case (lslc_pkg::cfg_reg_e'(cfg_idx_i))
        lslc_pkg::REG_STROBE_PERIOD: period_q <= cfg_data_i;
        lslc_pkg::REG_EDGE_GUARD:    guard_q  <= cfg_data_i[lslc_pkg::GuardW-1:0];
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      armed_q   <= 1'b1;
      saved_q   <= '{default: '0};
      run_q     <= 1'b0;
      count_q   <= '0;
      strobe_q  <= 1'b0;
      uv_cmp_q  <= '0;
      uv_en_q   <= 1'b0;
      vis_cmp_q <= '0;
      vis_en_q  <= 1'b0;
      pend_q    <= lslc_pkg::LenDefault;
    end else if (accept) begin
      active_q  <= active_d;
      armed_q   <= armed_d;
      saved_q   <= saved_d;
      run_q     <= run_d;
      count_q   <= count_d;
      strobe_q  <= strobe_d;
      uv_cmp_q  <= uv_cmp_d;
      uv_en_q   <= uv_en_d;
      vis_cmp_q <= vis_cmp_d;
      vis_en_q  <= vis_en_d;
      pend_q    <= pend_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(lslc_pkg::OutDataW-$bits(lslc_pkg::result_t)){1'b0}}, res_q};

endmodule
`default_nettype wire

/* design/lslc_checker.sv */
// port-level checker for the led strobe light controller, bound to the top level
`default_nettype none
module lslc_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tready,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [lslc_pkg::OutDataW-1:0]     m_axis_tdata
);

  lslc_pkg::result_t res;
  assign res = m_axis_tdata[$bits(lslc_pkg::result_t)-1:0];

  // a stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // input is refused only while a result waits on a stalled receiver
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
    else $error("input ready does not follow output stall");

  // inactive block shows all lights and strobe off
  a_inactive_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.output_active |->
      !res.strobe_out && !res.uv_on && !res.vis_on
      && res.strobe_length == lslc_pkg::LenDefault)
    else $error("output enabled while inactive");

  // light enables agree with compare values, which are odd when on
  a_duty_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (res.uv_on == (res.uv_duty != '0)) && (res.vis_on == (res.vis_duty != '0))
      && (!res.uv_on || res.uv_duty[0]) && (!res.vis_on || res.vis_duty[0]))
    else $error("compare value and enable disagree");

  // pulse end count is even and nonzero
  a_len_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !res.strobe_length[0] && res.strobe_length != '0)
    else $error("bad strobe pulse end count");

endmodule

bind led_strobe_light_controller lslc_checker u_lslc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
